>>> rtl/core/gwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared constants for the glob wildcard matcher.
// ----------------------------------------------------------------------------
package gwm_pkg;

	// Default number of pattern elements
	localparam int unsigned PATTERN_ELEMENTS = 32;

	// Byte width and depth of the per-byte accept table
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned TBL_DEPTH = 256;

	// Transaction operation codes
	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_PATTERN = 2'd1,
		OP_SUBJECT = 2'd2,
		OP_END     = 2'd3
	} op_t;

	// Pattern syntax bytes
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DASH   = 8'h2D;

	// ASCII case fold
	function automatic logic [7:0] fold(input logic [7:0] b, input logic ic);
		logic [7:0] r;
		r = b;
		if (ic && b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'd32;
		end
		return r;
	endfunction

endpackage

>>> rtl/core/gwm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gwm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/glob_wildcard_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glob_wildcard_matcher
// Compiles a glob pattern into a per-byte accept table plus element masks
// and matches streamed subject bytes against it bit-parallel.
// ----------------------------------------------------------------------------
// Subject byte: accept, then table read and active-set update.
// End of subject: result held in an output register.
// Pattern byte: accepted, then one read-modify-write on the table RAM for
// each table entry it sets (a range sets up to 256 entries).
// Clear, and reset: a sweep zeroing all 256 accept-table entries; no input
// transactions are taken meanwhile. Reset is asynchronous, active low.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher #(
	parameter int unsigned PATTERN_ELEMENTS = gwm_pkg::PATTERN_ELEMENTS
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: ASCII case folding enable
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [1:0] operation, [9:2] data_byte, rest zero
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [0] matched, [1] pattern_overflow, rest zero
);

	localparam int unsigned PE = PATTERN_ELEMENTS;
	localparam int unsigned CW = $clog2(PE + 1);
	localparam int unsigned AW = $clog2(gwm_pkg::TBL_DEPTH);

	typedef enum logic [2:0] {
		ST_CLR, ST_IDLE, ST_STEP, ST_RD, ST_WR
	} state_t;

	typedef enum logic [2:0] {
		PM_NORMAL, PM_ESC, PM_CLS_FIRST, PM_CLS, PM_CLS_SE,
		PM_CLS_ESC, PM_CLS_ESC_NS, PM_CLS_DASH
	} pmode_t;

	state_t          state_q;
	pmode_t          mode_q;
	logic            ic_q;
	logic [PE-1:0]   any_q, star_q, inv_q, dead_q, wbit_q;
	logic [CW-1:0]   cnt_q;
	logic [PE:0]     act_q;
	logic [7:0]      rlow_q;
	logic            ovf_q;
	logic [AW-1:0]   addr_q, hi_q;
	logic            m_valid_q;
	logic [1:0]      m_res_q;

	// input fields
	logic [1:0]      op;
	logic [7:0]      x, fx;
	logic            in_acc;

	assign op     = s_tdata[1:0];
	assign x      = s_tdata[9:2];
	assign fx     = gwm_pkg::fold(x, ic_q);
	assign s_tready = (state_q == ST_IDLE) && (!m_valid_q || m_tready);
	assign in_acc = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, m_res_q};

	// table RAM
	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [PE-1:0]   ram_wdata, ram_rdata;

	gwm_ram #(.WIDTH(PE), .DEPTH(gwm_pkg::TBL_DEPTH)) u_tbl (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		ram_we    = (state_q == ST_CLR) || (state_q == ST_WR);
		ram_waddr = addr_q;
		ram_wdata = (state_q == ST_CLR) ? '0 : (ram_rdata | wbit_q);
		ram_re    = (state_q == ST_RD) ||
			(in_acc && gwm_pkg::op_t'(op) == gwm_pkg::OP_SUBJECT);
		ram_raddr = (state_q == ST_RD) ? addr_q : fx;
	end

	// star closure as a carry chain: carry into bit i means position i reached
	logic [PE:0] cl_a, cl_b, cl_sum, closed;
	always_comb begin
		cl_a   = {1'b0, star_q};
		cl_b   = {1'b0, act_q[PE-1:0] & star_q};
		cl_sum = cl_a + cl_b;
		closed = act_q | (cl_sum ^ cl_a ^ cl_b);
	end

	// one subject step
	logic [PE-1:0] adv;
	logic [PE:0]   next_act;
	always_comb begin
		adv      = closed[PE-1:0] & ~star_q & ~dead_q & (any_q | (ram_rdata ^ inv_q));
		next_act = {adv, 1'b0} | {1'b0, closed[PE-1:0] & star_q};
	end

	// pattern byte parser
	logic [PE-1:0] cur_bit, new_bit, n_any, n_star, n_inv, n_dead, w_bit;
	logic [CW-1:0] n_cnt;
	pmode_t        n_mode;
	logic [7:0]    n_rlow, w_lo, w_hi;
	logic          n_ovf, w_req;

	always_comb begin
		cur_bit = (cnt_q == '0) ? '0 : ({{(PE-1){1'b0}}, 1'b1} << (cnt_q - CW'(1)));
		new_bit = {{(PE-1){1'b0}}, 1'b1} << cnt_q;
		n_any  = any_q;
		n_star = star_q;
		n_inv  = inv_q;
		n_dead = dead_q;
		n_cnt  = cnt_q;
		n_mode = mode_q;
		n_rlow = rlow_q;
		n_ovf  = ovf_q;
		w_req  = 1'b0;
		w_lo   = fx;
		w_hi   = fx;
		w_bit  = cur_bit;
		if (!ovf_q) begin
			unique case (mode_q)
				PM_NORMAL: begin
					if (cnt_q >= CW'(PE)) begin
						n_ovf = 1'b1;
					end else begin
						w_bit = new_bit;
						n_cnt = cnt_q + CW'(1);
						if (x == gwm_pkg::CH_QUEST) begin
							n_any = any_q | new_bit;
						end else if (x == gwm_pkg::CH_STAR) begin
							n_star = star_q | new_bit;
						end else if (x == gwm_pkg::CH_LBRACK) begin
							n_dead = dead_q | new_bit;
							n_rlow = '0;
							n_mode = PM_CLS_FIRST;
						end else if (x == gwm_pkg::CH_BSLASH) begin
							n_dead = dead_q | new_bit;
							n_mode = PM_ESC;
						end else begin
							w_req = 1'b1;
						end
					end
				end
				PM_ESC: begin
					w_req  = 1'b1;
					n_dead = dead_q & ~cur_bit;
					n_mode = PM_NORMAL;
				end
				PM_CLS_FIRST, PM_CLS: begin
					if (mode_q == PM_CLS_FIRST &&
						(x == gwm_pkg::CH_BANG || x == gwm_pkg::CH_CARET) &&
						(inv_q & cur_bit) == '0) begin
						n_inv = inv_q | cur_bit;
					end else if (mode_q == PM_CLS_FIRST && x == gwm_pkg::CH_DASH) begin
						w_req  = 1'b1;
						n_rlow = fx;
						n_mode = PM_CLS;
					end else if (x == gwm_pkg::CH_RBRACK) begin
						n_dead = dead_q & ~cur_bit;
						n_mode = PM_NORMAL;
					end else if (x == gwm_pkg::CH_BSLASH) begin
						n_mode = PM_CLS_ESC;
					end else if (x == gwm_pkg::CH_DASH) begin
						n_mode = PM_CLS_DASH;
					end else begin
						w_req  = 1'b1;
						n_rlow = fx;
						n_mode = PM_CLS;
					end
				end
				PM_CLS_SE: begin
					if (x == gwm_pkg::CH_BSLASH) begin
						n_mode = PM_CLS_ESC_NS;
					end else if (x == gwm_pkg::CH_DASH) begin
						n_mode = PM_CLS_DASH;
					end else begin
						w_req  = 1'b1;
						n_rlow = fx;
						n_mode = PM_CLS;
					end
				end
				PM_CLS_ESC: begin
					w_req  = 1'b1;
					n_rlow = fx;
					n_mode = PM_CLS;
				end
				PM_CLS_ESC_NS: begin
					if (x == gwm_pkg::CH_RBRACK) begin
						n_dead = dead_q & ~cur_bit;
						n_mode = PM_NORMAL;
					end else begin
						w_req  = 1'b1;
						n_rlow = fx;
						n_mode = (x == gwm_pkg::CH_BSLASH) ? PM_CLS_SE : PM_CLS;
					end
				end
				PM_CLS_DASH: begin
					w_req = 1'b1;
					if (x == gwm_pkg::CH_RBRACK) begin
						w_lo   = gwm_pkg::CH_DASH;
						w_hi   = gwm_pkg::CH_DASH;
						n_dead = dead_q & ~cur_bit;
						n_mode = PM_NORMAL;
					end else begin
						w_lo   = (rlow_q > fx) ? fx : rlow_q;
						w_hi   = (rlow_q > fx) ? rlow_q : fx;
						n_rlow = '0;
						n_mode = (x == gwm_pkg::CH_BSLASH) ? PM_CLS_SE : PM_CLS;
					end
				end
				default: ;
			endcase
		end
	end

	// control, pattern state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			mode_q    <= PM_NORMAL;
			ic_q      <= 1'b0;
			any_q     <= '0;
			star_q    <= '0;
			inv_q     <= '0;
			dead_q    <= '0;
			wbit_q    <= '0;
			cnt_q     <= '0;
			act_q     <= {{PE{1'b0}}, 1'b1};
			rlow_q    <= '0;
			ovf_q     <= 1'b0;
			addr_q    <= '0;
			hi_q      <= '0;
			m_valid_q <= 1'b0;
			m_res_q   <= '0;
		end else begin
			if (cfg_we) begin
				ic_q <= cfg_wdata;
			end
			// result valid: set on end of subject, else cleared when taken
			if (in_acc && gwm_pkg::op_t'(op) == gwm_pkg::OP_END) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					addr_q <= addr_q + AW'(1);
					if (addr_q == AW'(gwm_pkg::TBL_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						unique case (gwm_pkg::op_t'(op))
							gwm_pkg::OP_CLEAR: begin
								any_q   <= '0;
								star_q  <= '0;
								inv_q   <= '0;
								dead_q  <= '0;
								cnt_q   <= '0;
								act_q   <= {{PE{1'b0}}, 1'b1};
								mode_q  <= PM_NORMAL;
								rlow_q  <= '0;
								ovf_q   <= 1'b0;
								addr_q  <= '0;
								state_q <= ST_CLR;
							end
							gwm_pkg::OP_PATTERN: begin
								any_q  <= n_any;
								star_q <= n_star;
								inv_q  <= n_inv;
								dead_q <= n_dead;
								cnt_q  <= n_cnt;
								mode_q <= n_mode;
								rlow_q <= n_rlow;
								ovf_q  <= n_ovf;
								wbit_q <= w_bit;
								addr_q <= w_lo;
								hi_q   <= w_hi;
								if (w_req) begin
									state_q <= ST_RD;
								end
							end
							gwm_pkg::OP_SUBJECT: begin
								state_q <= ST_STEP;
							end
							gwm_pkg::OP_END: begin
								m_res_q   <= {ovf_q, !ovf_q && closed[cnt_q]};
								act_q     <= {{PE{1'b0}}, 1'b1};
							end
							default: ;
						endcase
					end
				end
				ST_STEP: begin
					act_q   <= next_act;
					state_q <= ST_IDLE;
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (addr_q == hi_q) begin
						state_q <= ST_IDLE;
					end else begin
						addr_q  <= addr_q + AW'(1);
						state_q <= ST_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
